[rtl/core/mtc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtc_pkg: motor thermal torque cap shared definitions
// Widths, register map, sequencer states and small helpers.
// ----------------------------------------------------------------------------
package mtc_pkg;

  localparam int FRAC_BITS = 16;                   // filter accumulator fraction bits
  localparam int ACC_W     = 32;                   // filter accumulator width
  localparam int RAW_W     = 8;
  localparam int TEMP_W    = 10;                   // degC fields
  localparam int TSUM_W    = TEMP_W + 1;           // raw + offset, with headroom
  localparam int PCT_W     = 7;
  localparam int SHIFT_W   = 4;
  localparam int FILT_W    = ACC_W + 1 - FRAC_BITS; // rounded filter value
  localparam int SPAN_W    = TEMP_W;               // limit - start, positive in the ramp
  localparam int PROD_W    = PCT_W + SPAN_W;       // drop * position
  localparam int QUOT_W    = PCT_W;
  localparam int DIV_CNT_W = $clog2(QUOT_W);
  localparam int ADDR_W    = 5;
  localparam int DATA_W    = 32;

  localparam logic [PCT_W-1:0] PCT_FULL = PCT_W'(100);

  // register map, word index
  typedef enum logic [2:0] {
    REG_RAW_OFFSET    = 3'd0,
    REG_DISCONNECT    = 3'd1,
    REG_MIN_PLAUSIBLE = 3'd2,
    REG_DERATE_START  = 3'd3,
    REG_DERATE_LIMIT  = 3'd4,
    REG_FLOOR_PCT     = 3'd5,
    REG_UNKNOWN_CAP   = 3'd6,
    REG_FILTER_SHIFT  = 3'd7
  } reg_idx_e;

  localparam logic [RAW_W-1:0]   RST_RAW_OFFSET    = 8'hCE;   // -50
  localparam logic [RAW_W-1:0]   RST_DISCONNECT    = 8'hFF;
  localparam logic [TEMP_W-1:0]  RST_MIN_PLAUSIBLE = 10'h3D8; // -40
  localparam logic [TEMP_W-1:0]  RST_DERATE_START  = 10'd90;
  localparam logic [TEMP_W-1:0]  RST_DERATE_LIMIT  = 10'd110;
  localparam logic [PCT_W-1:0]   RST_FLOOR_PCT     = 7'd20;
  localparam logic [PCT_W-1:0]   RST_UNKNOWN_CAP   = 7'd60;
  localparam logic [SHIFT_W-1:0] RST_FILTER_SHIFT  = 4'd8;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FILT,
    ST_ROUND,
    ST_RAMP,
    ST_DIV,
    ST_DONE
  } state_e;

  function automatic logic [PCT_W-1:0] sat_pct(input logic [PCT_W-1:0] p);
    sat_pct = (p > PCT_FULL) ? PCT_FULL : p;
  endfunction

endpackage

[rtl/core/mtc_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtc_div: restoring divider for the derating ramp
// One quotient bit per cycle; quotient known to fit QUOT_W bits.
// ----------------------------------------------------------------------------
module mtc_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [mtc_pkg::PROD_W-1:0]    dividend_i,
  input  logic [mtc_pkg::SPAN_W-1:0]    divisor_i,
  output logic                          done_o,
  output logic [mtc_pkg::QUOT_W-1:0]    quotient_o
);
  import mtc_pkg::*;

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [PROD_W-1:0]    rem_q, rem_d;
  logic [SPAN_W-1:0]    den_q, den_d;
  logic [QUOT_W-1:0]    quot_q, quot_d;
  logic [PROD_W-1:0]    trial;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    den_d  = den_q;
    quot_d = quot_q;
    trial  = {{PCT_W{1'b0}}, den_q} << cnt_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = DIV_CNT_W'(QUOT_W - 1);
      rem_d  = dividend_i;
      den_d  = divisor_i;
      quot_d = '0;
    end else if (busy_q) begin
      if (rem_q >= trial) begin
        rem_d          = rem_q - trial;
        quot_d[cnt_q]  = 1'b1;
      end
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    den_q  <= den_d;
    quot_q <= quot_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quot_q;

endmodule

[rtl/core/motor_thermal_torque_cap.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// motor_thermal_torque_cap: thermal derating with EMA-filtered temperature
// Picks the hottest valid motor sensor, filters it and maps it to a torque cap.
// ----------------------------------------------------------------------------
// Usage:
//  Input channel (in_valid_i/in_ready_o) carries one sensor sample per beat:
//  fresh flag and two raw counts. Output channel (out_valid_o/out_ready_i)
//  returns one result beat per sample: validity flags, cap, filtered and
//  hottest temperature.
//  One sample at a time goes through a small sequencer: filter update, round,
//  ramp compare, then a restoring divider (one quotient bit per cycle) when the
//  temperature lies inside the ramp. With no valid sensor the sequencer goes
//  from the filter step straight to the result; the ramp compare settles a cap
//  of 100 or the floor; otherwise the divider runs its seven steps. Then
//  the result is registered. in_ready_o rises again with it, so a new sample
//  is taken only once the last one has left the sequencer.
//  A result waiting in the output register does not block the next sample;
//  the sequencer holds its finished result until the output register frees.
//  Reset loads the default register values, unseeds the filter, sets the last
//  cap to 100 and empties the output register. Configure through the APB port
//  (pready always high, word addresses) only while idle; the block won't check.
// ----------------------------------------------------------------------------
module motor_thermal_torque_cap (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [mtc_pkg::ADDR_W-1:0]     paddr,
  input  logic [mtc_pkg::DATA_W-1:0]     pwdata,
  output logic [mtc_pkg::DATA_W-1:0]     prdata,
  output logic                           pready,
  // sample in
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           fresh_i,
  input  logic [mtc_pkg::RAW_W-1:0]      temp1_raw_i,
  input  logic [mtc_pkg::RAW_W-1:0]      temp2_raw_i,
  // result out
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic                           sens1_ok_o,
  output logic                           sens2_ok_o,
  output logic                           unknown_o,
  output logic [mtc_pkg::PCT_W-1:0]      cap_pct_o,
  output logic                           capped_o,
  output logic [mtc_pkg::TEMP_W-1:0]     filtered_degc_o,
  output logic [mtc_pkg::TEMP_W-1:0]     hottest_degc_o
);
  import mtc_pkg::*;

  // configuration registers
  logic [RAW_W-1:0]   offset_q;
  logic [RAW_W-1:0]   disc_q;
  logic [TEMP_W-1:0]  minp_q;
  logic [TEMP_W-1:0]  start_q;
  logic [TEMP_W-1:0]  limit_q;
  logic [PCT_W-1:0]   floor_q;
  logic [PCT_W-1:0]   ucap_q;
  logic [SHIFT_W-1:0] shift_q;
  logic               cfg_wr;
  reg_idx_e           cfg_idx;

  // sequencer and item state
  state_e              state_q, state_d;
  logic                seeded_q, seeded_d;
  logic [ACC_W-1:0]    acc_q, acc_d;
  logic [PCT_W-1:0]    last_cap_q, last_cap_d;
  logic                s1_q, s1_d, s2_q, s2_d;
  logic [TSUM_W-1:0]   hot_q, hot_d;
  logic [FILT_W-1:0]   filt_q, filt_d;
  logic [PCT_W-1:0]    cap_q, cap_d;

  // output register
  logic                out_valid_q, out_valid_d;
  logic                o_s1_q, o_s1_d, o_s2_q, o_s2_d, o_unk_q, o_unk_d, o_capped_q, o_capped_d;
  logic [PCT_W-1:0]    o_cap_q, o_cap_d;
  logic [TEMP_W-1:0]   o_filt_q, o_filt_d, o_hot_q, o_hot_d;

  // datapath
  logic [TSUM_W-1:0]   offset_x, minp_x, t1, t2;
  logic                v1, v2;
  logic [ACC_W:0]      acc_x, target, diff, step, acc_sum, rnd;
  logic [FILT_W-1:0]   start_x, limit_x, pos_x, span_x;
  logic [PCT_W-1:0]    floor_sat, ucap_sat;
  logic [PROD_W-1:0]   prod;
  logic                div_start, div_done;
  logic [QUOT_W-1:0]   quot;

  // ---------------- configuration port ----------------
  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_idx = reg_idx_e'(paddr[ADDR_W-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q <= RST_RAW_OFFSET;
      disc_q   <= RST_DISCONNECT;
      minp_q   <= RST_MIN_PLAUSIBLE;
      start_q  <= RST_DERATE_START;
      limit_q  <= RST_DERATE_LIMIT;
      floor_q  <= RST_FLOOR_PCT;
      ucap_q   <= RST_UNKNOWN_CAP;
      shift_q  <= RST_FILTER_SHIFT;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_RAW_OFFSET:    offset_q <= pwdata[RAW_W-1:0];
        REG_DISCONNECT:    disc_q   <= pwdata[RAW_W-1:0];
        REG_MIN_PLAUSIBLE: minp_q   <= pwdata[TEMP_W-1:0];
        REG_DERATE_START:  start_q  <= pwdata[TEMP_W-1:0];
        REG_DERATE_LIMIT:  limit_q  <= pwdata[TEMP_W-1:0];
        REG_FLOOR_PCT:     floor_q  <= pwdata[PCT_W-1:0];
        REG_UNKNOWN_CAP:   ucap_q   <= pwdata[PCT_W-1:0];
        REG_FILTER_SHIFT:  shift_q  <= pwdata[SHIFT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_RAW_OFFSET:    prdata = {{(DATA_W-RAW_W){offset_q[RAW_W-1]}}, offset_q};
      REG_DISCONNECT:    prdata = {{(DATA_W-RAW_W){1'b0}}, disc_q};
      REG_MIN_PLAUSIBLE: prdata = {{(DATA_W-TEMP_W){minp_q[TEMP_W-1]}}, minp_q};
      REG_DERATE_START:  prdata = {{(DATA_W-TEMP_W){start_q[TEMP_W-1]}}, start_q};
      REG_DERATE_LIMIT:  prdata = {{(DATA_W-TEMP_W){limit_q[TEMP_W-1]}}, limit_q};
      REG_FLOOR_PCT:     prdata = {{(DATA_W-PCT_W){1'b0}}, floor_q};
      REG_UNKNOWN_CAP:   prdata = {{(DATA_W-PCT_W){1'b0}}, ucap_q};
      REG_FILTER_SHIFT:  prdata = {{(DATA_W-SHIFT_W){1'b0}}, shift_q};
      default:           prdata = '0;
    endcase
  end

  // ---------------- datapath ----------------
  assign offset_x = {{(TSUM_W-RAW_W){offset_q[RAW_W-1]}}, offset_q};
  assign minp_x   = {minp_q[TEMP_W-1], minp_q};
  assign t1       = {{(TSUM_W-RAW_W){1'b0}}, temp1_raw_i} + offset_x;
  assign t2       = {{(TSUM_W-RAW_W){1'b0}}, temp2_raw_i} + offset_x;
  assign v1 = fresh_i && (temp1_raw_i != disc_q) && ($signed(t1) >= $signed(minp_x));
  assign v2 = fresh_i && (temp2_raw_i != disc_q) && ($signed(t2) >= $signed(minp_x));

  assign acc_x   = {acc_q[ACC_W-1], acc_q};
  assign target  = {{(ACC_W+1-TSUM_W){hot_q[TSUM_W-1]}}, hot_q} << FRAC_BITS;
  assign diff    = target - acc_x;
  assign step    = $signed(diff) >>> shift_q;
  assign acc_sum = acc_x + step;
  assign rnd     = acc_x + ((ACC_W+1)'(1) << (FRAC_BITS - 1));

  assign start_x   = {{(FILT_W-TEMP_W){start_q[TEMP_W-1]}}, start_q};
  assign limit_x   = {{(FILT_W-TEMP_W){limit_q[TEMP_W-1]}}, limit_q};
  assign pos_x     = filt_q - start_x;
  assign span_x    = limit_x - start_x;
  assign floor_sat = sat_pct(floor_q);
  assign ucap_sat  = sat_pct(ucap_q);
  assign prod = {{SPAN_W{1'b0}}, PCT_FULL - floor_sat} * {{PCT_W{1'b0}}, pos_x[SPAN_W-1:0]};

  mtc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (prod),
    .divisor_i  (span_x[SPAN_W-1:0]),
    .done_o     (div_done),
    .quotient_o (quot)
  );

  // ---------------- sequencer ----------------
  always_comb begin
    state_d     = state_q;
    seeded_d    = seeded_q;
    acc_d       = acc_q;
    last_cap_d  = last_cap_q;
    s1_d        = s1_q;
    s2_d        = s2_q;
    hot_d       = hot_q;
    filt_d      = filt_q;
    cap_d       = cap_q;
    div_start   = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    o_s1_d      = o_s1_q;
    o_s2_d      = o_s2_q;
    o_unk_d     = o_unk_q;
    o_capped_d  = o_capped_q;
    o_cap_d     = o_cap_q;
    o_filt_d    = o_filt_q;
    o_hot_d     = o_hot_q;
    in_ready_o  = (state_q == ST_IDLE);

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          s1_d = v1;
          s2_d = v2;
          if (v1 && v2) begin
            hot_d = ($signed(t1) > $signed(t2)) ? t1 : t2;
          end else if (v1) begin
            hot_d = t1;
          end else if (v2) begin
            hot_d = t2;
          end else begin
            hot_d = '0;
          end
          state_d = ST_FILT;
        end
      end
      ST_FILT: begin
        if (!s1_q && !s2_q) begin
          // no valid sensor: unseed, cap only ratchets down
          seeded_d = 1'b0;
          cap_d    = (ucap_sat < last_cap_q) ? ucap_sat : last_cap_q;
          state_d  = ST_DONE;
        end else begin
          seeded_d = 1'b1;
          acc_d    = seeded_q ? acc_sum[ACC_W-1:0] : target[ACC_W-1:0];
          state_d  = ST_ROUND;
        end
      end
      ST_ROUND: begin
        filt_d  = rnd[ACC_W:FRAC_BITS];
        state_d = ST_RAMP;
      end
      ST_RAMP: begin
        if ($signed(filt_q) <= $signed(start_x)) begin
          cap_d   = PCT_FULL;
          state_d = ST_DONE;
        end else if ($signed(filt_q) >= $signed(limit_x)) begin
          cap_d   = floor_sat;
          state_d = ST_DONE;
        end else begin
          div_start = 1'b1;
          state_d   = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          cap_d   = PCT_FULL - quot;
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          o_s1_d      = s1_q;
          o_s2_d      = s2_q;
          o_unk_d     = !s1_q && !s2_q;
          o_cap_d     = cap_q;
          o_capped_d  = (cap_q < PCT_FULL);
          o_filt_d    = (!s1_q && !s2_q) ? '0 : filt_q[TEMP_W-1:0];
          o_hot_d     = hot_q[TEMP_W-1:0];
          last_cap_d  = cap_q;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      seeded_q    <= 1'b0;
      acc_q       <= '0;
      last_cap_q  <= PCT_FULL;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      seeded_q    <= seeded_d;
      acc_q       <= acc_d;
      last_cap_q  <= last_cap_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_q       <= s1_d;
    s2_q       <= s2_d;
    hot_q      <= hot_d;
    filt_q     <= filt_d;
    cap_q      <= cap_d;
    o_s1_q     <= o_s1_d;
    o_s2_q     <= o_s2_d;
    o_unk_q    <= o_unk_d;
    o_capped_q <= o_capped_d;
    o_cap_q    <= o_cap_d;
    o_filt_q   <= o_filt_d;
    o_hot_q    <= o_hot_d;
  end

  assign out_valid_o     = out_valid_q;
  assign sens1_ok_o      = o_s1_q;
  assign sens2_ok_o      = o_s2_q;
  assign unknown_o       = o_unk_q;
  assign cap_pct_o       = o_cap_q;
  assign capped_o        = o_capped_q;
  assign filtered_degc_o = o_filt_q;
  assign hottest_degc_o  = o_hot_q;

  // ---------------- assertions ----------------
  a_one_beat_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("sample accepted while another is in progress");

  a_div_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == ST_DIV))
    else $error("divider finished outside the divide step");

  a_cap_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (cap_pct_o <= PCT_FULL))
    else $error("cap above 100 percent");

  a_unknown_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && unknown_o) |->
      (!sens1_ok_o && !sens2_ok_o && filtered_degc_o == '0 && hottest_degc_o == '0))
    else $error("unknown result carries sensor data");

endmodule

[test/motor_thermal_torque_cap_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// motor_thermal_torque_cap_test: self-checking bench for the torque cap block
// A directed table (register writes and samples) runs first. Random sample
// streams follow under several register settings and idle patterns. Every
// result beat is checked against its row's typed expectation, or else a local
// model of sensor qualification, the fixed-point filter and the derating ramp.
// ----------------------------------------------------------------------------
module motor_thermal_torque_cap_test;
  import mtc_pkg::*;

  localparam int STALL_LIMIT = 4000;
  localparam int PHASE_ITEMS = 135;
  localparam int NUM_PHASES  = 8;
  localparam int NUM_REGS    = 8;

  typedef struct packed {
    logic              sens1_ok;
    logic              sens2_ok;
    logic              unknown;
    logic [PCT_W-1:0]  cap_pct;
    logic              capped;
    logic [TEMP_W-1:0] filtered_degc;
    logic [TEMP_W-1:0] hottest_degc;
  } torque_result_t;

  typedef struct {
    bit               is_write;
    reg_idx_e         idx;
    int               wval;
    logic             fresh;
    logic [RAW_W-1:0] raw1;
    logic [RAW_W-1:0] raw2;
    bit               typed;
    torque_result_t   want;
  } stim_row_t;

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              psel        = 1'b0;
  logic              penable     = 1'b0;
  logic              pwrite      = 1'b0;
  logic [ADDR_W-1:0] paddr       = '0;
  logic [DATA_W-1:0] pwdata      = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;
  logic              in_valid_i  = 1'b0;
  logic              in_ready_o;
  logic              fresh_i     = 1'b0;
  logic [RAW_W-1:0]  temp1_raw_i = '0;
  logic [RAW_W-1:0]  temp2_raw_i = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic              sens1_ok_o;
  logic              sens2_ok_o;
  logic              unknown_o;
  logic [PCT_W-1:0]  cap_pct_o;
  logic              capped_o;
  logic [TEMP_W-1:0] filtered_degc_o;
  logic [TEMP_W-1:0] hottest_degc_o;

  // typed expectation travels with the sample beat
  bit             row_typed = 1'b0;
  torque_result_t row_want  = '0;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int sent_cnt       = 0;
  int done_cnt       = 0;
  int mismatches     = 0;
  int quiet_cycles   = 0;

  torque_result_t expected_caps[$];

  // register mirror, decoded
  int offset_degc = -50;
  int disc_code   = 255;
  int min_degc    = -40;
  int start_degc  = 90;
  int limit_degc  = 110;
  int floor_pct   = 20;
  int unk_cap_pct = 60;
  int flt_shift   = 8;

  // filter state
  bit flt_seeded = 1'b0;
  int flt_acc    = 0;
  int last_cap   = 100;

  // offset, disconnect, min, start, limit, floor, unknown cap, shift
  int phase_cfg [6][NUM_REGS] = '{
    '{ -50, 255,  -40,   90,  110,  20,  60,  8},
    '{-128,   0, -128, -128,  383,   0,   0,  0},
    '{ 127, 128,  200,  300, -128,   0, 100, 15},
    '{   0,  77,    0,   50,   51, 127, 127,  1},
    '{ -10, 200,   20,   60,   60,  35, 101,  4},
    '{ -50, 255,  -40,  100,  200,   5,  30,  2}
  };

  motor_thermal_torque_cap i_dut (.*);

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  function automatic torque_result_t predict_torque_cap(logic fresh,
                                                        logic [RAW_W-1:0] raw1,
                                                        logic [RAW_W-1:0] raw2);
    int             t1, t2, hot, filt, fl, cap;
    bit             v1, v2;
    longint         target, acc;
    torque_result_t res;
    t1   = int'(raw1) + offset_degc;
    t2   = int'(raw2) + offset_degc;
    v1   = fresh && int'(raw1) != disc_code && t1 >= min_degc;
    v2   = fresh && int'(raw2) != disc_code && t2 >= min_degc;
    hot  = 0;
    filt = 0;
    if (!v1 && !v2) begin
      // no trusted sensor: unseed, cap may only ratchet down
      fl         = (unk_cap_pct > 100) ? 100 : unk_cap_pct;
      flt_seeded = 1'b0;
      cap        = (fl < last_cap) ? fl : last_cap;
    end else begin
      if (v1 && v2) begin
        hot = (t1 > t2) ? t1 : t2;
      end else begin
        hot = v1 ? t1 : t2;
      end
      target = longint'(hot) <<< FRAC_BITS;
      if (!flt_seeded) begin
        flt_acc    = int'(target);
        flt_seeded = 1'b1;
      end else begin
        acc     = flt_acc;
        acc     = acc + ((target - acc) >>> flt_shift);
        flt_acc = int'(acc);
      end
      filt = int'((longint'(flt_acc) + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS);
      fl   = (floor_pct > 100) ? 100 : floor_pct;
      if (filt <= start_degc) begin
        cap = 100;
      end else if (filt >= limit_degc) begin
        cap = fl;
      end else begin
        cap = 100 - (100 - fl) * (filt - start_degc) / (limit_degc - start_degc);
      end
    end
    last_cap          = cap;
    res.sens1_ok      = v1;
    res.sens2_ok      = v2;
    res.unknown       = !v1 && !v2;
    res.cap_pct       = PCT_W'(cap);
    res.capped        = (cap < 100);
    res.filtered_degc = TEMP_W'(filt);
    res.hottest_degc  = TEMP_W'(hot);
    return res;
  endfunction

  function automatic torque_result_t result_of(bit s1, bit s2, int cap, int filt, int hot);
    torque_result_t res;
    res.sens1_ok      = s1;
    res.sens2_ok      = s2;
    res.unknown       = !s1 && !s2;
    res.cap_pct       = PCT_W'(cap);
    res.capped        = (cap < 100);
    res.filtered_degc = TEMP_W'(filt);
    res.hottest_degc  = TEMP_W'(hot);
    return res;
  endfunction

  function automatic stim_row_t sample_row(logic fresh, int raw1, int raw2);
    stim_row_t row;
    row.is_write = 1'b0;
    row.idx      = REG_RAW_OFFSET;
    row.wval     = 0;
    row.fresh    = fresh;
    row.raw1     = RAW_W'(raw1);
    row.raw2     = RAW_W'(raw2);
    row.typed    = 1'b0;
    row.want     = '0;
    return row;
  endfunction

  function automatic stim_row_t typed_row(logic fresh, int raw1, int raw2,
                                          torque_result_t want);
    stim_row_t row;
    row       = sample_row(fresh, raw1, raw2);
    row.typed = 1'b1;
    row.want  = want;
    return row;
  endfunction

  function automatic stim_row_t write_row(reg_idx_e idx, int value);
    stim_row_t row;
    row          = sample_row(1'b0, 0, 0);
    row.is_write = 1'b1;
    row.idx      = idx;
    row.wval     = value;
    return row;
  endfunction

  function automatic int clamp_raw(int v);
    return (v < 0) ? 0 : ((v > 255) ? 255 : v);
  endfunction

  task automatic note_mismatch(string msg);
    mismatches++;
    if (mismatches <= 10) begin
      $display("[%0t] MISMATCH %s", $realtime, msg);
    end
  endtask

  task automatic apb_write(reg_idx_e idx, int value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= DATA_W'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_sample(logic fresh, logic [RAW_W-1:0] raw1, logic [RAW_W-1:0] raw2,
                             bit typed, torque_result_t want);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    fresh_i     <= fresh;
    temp1_raw_i <= raw1;
    temp2_raw_i <= raw2;
    row_typed   <= typed;
    row_want    <= want;
    sent_cnt++;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // block is idle once every sent sample has its result beat back
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (done_cnt != sent_cnt) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    torque_result_t got, want;
    string          diffs;
    if (rst_ni) begin
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_e'(paddr[4:2]))
          REG_RAW_OFFSET:    offset_degc = int'($signed(pwdata[7:0]));
          REG_DISCONNECT:    disc_code   = int'(pwdata[7:0]);
          REG_MIN_PLAUSIBLE: min_degc    = int'($signed(pwdata[9:0]));
          REG_DERATE_START:  start_degc  = int'($signed(pwdata[9:0]));
          REG_DERATE_LIMIT:  limit_degc  = int'($signed(pwdata[9:0]));
          REG_FLOOR_PCT:     floor_pct   = int'(pwdata[6:0]);
          REG_UNKNOWN_CAP:   unk_cap_pct = int'(pwdata[6:0]);
          REG_FILTER_SHIFT:  flt_shift   = int'(pwdata[3:0]);
          default: ;
        endcase
      end
      // check the result beat before queuing this edge's sample
      if (out_valid_o && out_ready_i) begin
        done_cnt++;
        got = {sens1_ok_o, sens2_ok_o, unknown_o, cap_pct_o, capped_o,
               filtered_degc_o, hottest_degc_o};
        if (expected_caps.size() == 0) begin
          note_mismatch($sformatf("unexpected result beat %p", got));
        end else begin
          want  = expected_caps.pop_front();
          diffs = "";
          if (got.sens1_ok !== want.sens1_ok)
            diffs = {diffs, $sformatf(" sens1_ok exp %0b got %0b", want.sens1_ok, got.sens1_ok)};
          if (got.sens2_ok !== want.sens2_ok)
            diffs = {diffs, $sformatf(" sens2_ok exp %0b got %0b", want.sens2_ok, got.sens2_ok)};
          if (got.unknown !== want.unknown)
            diffs = {diffs, $sformatf(" unknown exp %0b got %0b", want.unknown, got.unknown)};
          if (got.cap_pct !== want.cap_pct)
            diffs = {diffs, $sformatf(" cap_pct exp %0d got %0d", want.cap_pct, got.cap_pct)};
          if (got.capped !== want.capped)
            diffs = {diffs, $sformatf(" capped exp %0b got %0b", want.capped, got.capped)};
          if (got.filtered_degc !== want.filtered_degc)
            diffs = {diffs, $sformatf(" filtered_degc exp %0d got %0d",
                     $signed(want.filtered_degc), $signed(got.filtered_degc))};
          if (got.hottest_degc !== want.hottest_degc)
            diffs = {diffs, $sformatf(" hottest_degc exp %0d got %0d",
                     $signed(want.hottest_degc), $signed(got.hottest_degc))};
          if (diffs != "") note_mismatch({"result", diffs});
        end
      end
      if (in_valid_i && in_ready_o) begin
        want = predict_torque_cap(fresh_i, temp1_raw_i, temp2_raw_i);
        expected_caps.push_back(row_typed ? row_want : want);
      end
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
          $display("[%0t] no handshake for %0d cycles", $realtime, STALL_LIMIT);
          $display("Verification failed");
          $finish;
        end
      end
    end
  end

  initial begin
    stim_row_t rows[$];
    int        cur [NUM_REGS];
    int        kind, t, a, b, lo, hi;
    logic      fr;

    // directed table, reset register values unless a write row says otherwise
    rows.push_back(typed_row(0,   0,   0, result_of(0, 0,  60,   0,   0)));
    rows.push_back(typed_row(1, 255, 255, result_of(0, 0,  60,   0,   0)));
    rows.push_back(typed_row(1,   0,   0, result_of(0, 0,  60,   0,   0)));
    // sensor one exactly at the plausible minimum seeds the filter
    rows.push_back(typed_row(1,  10,   5, result_of(1, 0, 100, -40, -40)));
    rows.push_back(sample_row(1, 254,   0));
    rows.push_back(typed_row(0, 254, 254, result_of(0, 0,  60,   0,   0)));
    rows.push_back(typed_row(1, 254, 254, result_of(1, 1,  20, 204, 204)));
    rows.push_back(sample_row(1,   0, 254));
    // unknown after a floor cap keeps the lower cap
    rows.push_back(typed_row(1, 255,   0, result_of(0, 0,  20,   0,   0)));
    rows.push_back(typed_row(1, 140,   0, result_of(1, 0, 100,  90,  90)));
    rows.push_back(sample_row(1, 150, 150));
    rows.push_back(sample_row(1, 160, 158));
    rows.push_back(write_row(REG_FILTER_SHIFT, 0));
    rows.push_back(typed_row(1, 150,   0, result_of(1, 0,  60, 100, 100)));
    // limit equal to start: anything above start drops to the floor
    rows.push_back(write_row(REG_DERATE_LIMIT, 90));
    rows.push_back(typed_row(1, 141,   0, result_of(1, 0,  20,  91,  91)));
    rows.push_back(typed_row(1, 140,   0, result_of(1, 0, 100,  90,  90)));
    // percentages above 100 saturate
    rows.push_back(write_row(REG_FLOOR_PCT, 127));
    rows.push_back(typed_row(1, 200,   0, result_of(1, 0, 100, 150, 150)));
    rows.push_back(write_row(REG_UNKNOWN_CAP, 127));
    rows.push_back(typed_row(0,   0,   0, result_of(0, 0, 100,   0,   0)));
    rows.push_back(write_row(REG_DISCONNECT, 0));
    rows.push_back(write_row(REG_RAW_OFFSET, 127));
    rows.push_back(write_row(REG_MIN_PLAUSIBLE, -128));
    rows.push_back(typed_row(1,   0, 255, result_of(0, 1, 100, 382, 382)));
    rows.push_back(sample_row(1, 255, 255));

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) begin
      if (rows[i].is_write) begin
        wait_idle();
        apb_write(rows[i].idx, rows[i].wval);
      end else begin
        send_sample(rows[i].fresh, rows[i].raw1, rows[i].raw2, rows[i].typed, rows[i].want);
      end
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_idle();
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 54; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 54; end
        default: begin send_idle_pct = 7; recv_stall_pct = 7; end
      endcase
      if (p < 6) begin
        cur = phase_cfg[p];
      end else begin
        cur[REG_RAW_OFFSET]    = int'($urandom_range(255)) - 128;
        cur[REG_DISCONNECT]    = $urandom_range(255);
        cur[REG_MIN_PLAUSIBLE] = int'($urandom_range(250)) - 128;
        cur[REG_DERATE_START]  = int'($urandom_range(511)) - 128;
        cur[REG_DERATE_LIMIT]  = cur[REG_DERATE_START] + int'($urandom_range(80)) - 10;
        if (cur[REG_DERATE_LIMIT] > 383) cur[REG_DERATE_LIMIT] = 383;
        cur[REG_FLOOR_PCT]     = $urandom_range(127);
        cur[REG_UNKNOWN_CAP]   = $urandom_range(127);
        cur[REG_FILTER_SHIFT]  = $urandom_range(15);
      end
      for (int r = 0; r < NUM_REGS; r++) apb_write(reg_idx_e'(r), cur[r]);

      lo = (cur[REG_DERATE_START] < cur[REG_DERATE_LIMIT]) ?
           cur[REG_DERATE_START] : cur[REG_DERATE_LIMIT];
      hi = (cur[REG_DERATE_START] > cur[REG_DERATE_LIMIT]) ?
           cur[REG_DERATE_START] : cur[REG_DERATE_LIMIT];
      lo = lo - 8;
      hi = hi + 8;

      repeat (PHASE_ITEMS) begin
        kind = $urandom_range(99);
        if (kind < 70) begin
          // fresh samples aimed at the ramp so the filter sweeps through it
          fr = 1'b1;
          t  = lo + int'($urandom_range(hi - lo));
          a  = clamp_raw(t - cur[REG_RAW_OFFSET]);
          b  = $urandom_range(1) ? clamp_raw(a + int'($urandom_range(40)) - 20)
                                 : int'($urandom_range(255));
        end else if (kind < 85) begin
          fr = 1'($urandom_range(1));
          a  = $urandom_range(255);
          b  = $urandom_range(255);
        end else begin
          fr = 1'($urandom_range(1));
          a  = cur[REG_DISCONNECT];
          b  = $urandom_range(1) ? cur[REG_DISCONNECT] : int'($urandom_range(255));
        end
        if ($urandom_range(1)) begin
          t = a;
          a = b;
          b = t;
        end
        send_sample(fr, RAW_W'(a), RAW_W'(b), 1'b0, '0);
      end
    end

    wait_idle();
    repeat (16) @(posedge clk_i);
    if (mismatches == 0 && expected_caps.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
